FILE: src/tow_pkg.sv
// Shared types, constants and coefficient table for the tracking wheel odometry block.
package tow_pkg;

   typedef struct packed {
      logic [16:0]        heading_reading;
      logic signed [31:0] x_enc_a;
      logic signed [31:0] x_enc_b;
      logic signed [31:0] y_enc_a;
      logic signed [31:0] y_enc_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [16:0]        heading_out;
      logic               large_turn;
   } rsp_type;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_HEADING_ENABLE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_TRAVEL_SCALE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_TRAVEL_SCALE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_X_ARC_OFFSET    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_ARC_OFFSET    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_X_TRACKER_COUNT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_TRACKER_COUNT = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_MOUNT_ROTATION  = 3'd7;

   localparam int TRACKERS_PER_AXIS = 2;
   localparam logic [1:0] TRACK_MAX =
      (TRACKERS_PER_AXIS < 2) ? 2'(TRACKERS_PER_AXIS) : 2'd2;

   localparam logic [16:0] FULL_TURN = 17'd92160;
   localparam logic [15:0] QUART512  = 16'd46080;
   localparam logic [33:0] INVPI_Q30 = 34'd341782638;
   localparam logic [31:0] SIN_C9    = 32'd172272;

   // Horner coefficients of the quarter-wave sine series, applied after C9.
   function automatic logic [31:0] sin_coef(input logic [1:0] idx);
      logic [31:0] c;
      case (idx)
         2'd0:    c = 32'd5026995;
         2'd1:    c = 32'd85569306;
         2'd2:    c = 32'd693598668;
         default: c = 32'd1686629713;
      endcase
      return c;
   endfunction

endpackage

FILE: src/tracking_wheel_odometry.sv
// Throughput: one word at a time, set by the shared bit-serial multiplier and the restoring
// divider that all steps go through; the next word is accepted the cycle after the result
// word is loaded.
// Reset (synchronous, active high) clears the pose, stored counts and heading, and loads the
// register defaults; the next word only primes the stored values.
module tracking_wheel_odometry #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  tow_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output tow_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tow_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tow_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tow_pkg::*;

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_START = 5'd1;
   localparam logic [4:0] ST_TRV0  = 5'd2;
   localparam logic [4:0] ST_TRV1  = 5'd3;
   localparam logic [4:0] ST_TRV2  = 5'd4;
   localparam logic [4:0] ST_TRV3  = 5'd5;
   localparam logic [4:0] ST_ARC0  = 5'd6;
   localparam logic [4:0] ST_ARC1  = 5'd7;
   localparam logic [4:0] ST_ARC2  = 5'd8;
   localparam logic [4:0] ST_ARC3  = 5'd9;
   localparam logic [4:0] ST_ARC4  = 5'd10;
   localparam logic [4:0] ST_ARC5  = 5'd11;
   localparam logic [4:0] ST_ARC6  = 5'd12;
   localparam logic [4:0] ST_ARC7  = 5'd13;
   localparam logic [4:0] ST_ROT0  = 5'd14;
   localparam logic [4:0] ST_ROT1  = 5'd15;
   localparam logic [4:0] ST_ROT2  = 5'd16;
   localparam logic [4:0] ST_ROT3  = 5'd17;
   localparam logic [4:0] ST_ROT4  = 5'd18;
   localparam logic [4:0] ST_ROT5  = 5'd19;
   localparam logic [4:0] ST_ROT6  = 5'd20;
   localparam logic [4:0] ST_SIN0  = 5'd21;
   localparam logic [4:0] ST_SIN1  = 5'd22;
   localparam logic [4:0] ST_SIN2  = 5'd23;
   localparam logic [4:0] ST_SIN3  = 5'd24;
   localparam logic [4:0] ST_SIN4  = 5'd25;
   localparam logic [4:0] ST_OUT   = 5'd26;

   localparam logic [5:0] MUL_STEPS = 6'd34;
   localparam logic [5:0] DIV_STEPS = 6'd48;

   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      logic signed [31:0] r;
      if (v > 68'sd2147483647)
         r = 32'sh7fffffff;
      else if (v < -68'sd2147483648)
         r = 32'sh80000000;
      else
         r = v[31:0];
      return r;
   endfunction

   // Control and architectural state
   logic [4:0]             pc_ff, pc_in, ret_ff, ret_in;
   logic                   primed_ff, primed_in;
   logic [31:0]            acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic [16:0]            last_head_ff, last_head_in;
   logic [COUNT_WIDTH-1:0] last_x_ff [2], last_x_in [2];
   logic [COUNT_WIDTH-1:0] last_y_ff [2], last_y_in [2];
   logic                   hen_ff, hen_in;
   logic [23:0]            xscale_ff, xscale_in, yscale_ff, yscale_in;
   logic [23:0]            xoff_ff, xoff_in, yoff_ff, yoff_in;
   logic [1:0]             xcnt_ff, xcnt_in, ycnt_ff, ycnt_in;
   logic [16:0]            mrot_ff, mrot_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   // Working registers
   req_type                in_ff, in_in;
   logic [16:0]            rd_ff, rd_in;
   logic signed [17:0]     dh_ff, dh_in;
   logic                   large_ff, large_in;
   logic                   ax_ff, ax_in;
   logic signed [57:0]     sum_ff, sum_in;
   logic signed [31:0]     lx_ff, lx_in, ly_ff, ly_in;
   logic signed [31:0]     sdh_ff, sdh_in;
   logic [31:0]            k_ff, k_in;
   logic signed [67:0]     t_ff, t_in;
   logic signed [19:0]     sarg_ff, sarg_in;
   logic                   sneg_ff, sneg_in;
   logic [30:0]            x_ff, x_in, x2_ff, x2_in;
   logic [1:0]             pi_ff, pi_in;
   logic signed [31:0]     sn_ff, sn_in, rs_ff, rs_in, rc_ff, rc_in;

   // Shared multiplier and divider
   logic [5:0]             ecnt_ff, ecnt_in;
   logic signed [35:0]     mh_ff, mh_in;
   logic [33:0]            ml_ff, ml_in;
   logic signed [34:0]     mm_ff, mm_in;
   logic [47:0]            dq_ff, dq_in;
   logic [15:0]            dr_ff, dr_in, dd_ff, dd_in;
   logic                   ediv_ff, ediv_in;
   logic                   eng_busy, go, accept;
   logic                   mul_go, div_go;
   logic signed [33:0]     mul_a, mul_b;
   logic [47:0]            div_n;
   logic [15:0]            div_d;
   logic signed [67:0]     mprod;

   assign eng_busy  = (ecnt_ff != 6'd0);
   assign go        = !eng_busy;
   assign req_stall = (pc_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;
   assign mprod     = $signed({mh_ff[33:0], ml_ff});

   // One multiplier bit or one quotient bit per cycle.
   always_comb begin
      logic signed [35:0] msum;
      logic [16:0]        rsh, rdiff;
      logic               ge;
      msum    = mh_ff + (ml_ff[0] ? {mm_ff[34], mm_ff} : 36'sd0);
      rsh     = {dr_ff, dq_ff[47]};
      rdiff   = rsh - {1'b0, dd_ff};
      ge      = (rsh >= {1'b0, dd_ff});
      ecnt_in = ecnt_ff;
      mh_in   = mh_ff;
      ml_in   = ml_ff;
      mm_in   = mm_ff;
      dq_in   = dq_ff;
      dr_in   = dr_ff;
      dd_in   = dd_ff;
      ediv_in = ediv_ff;
      if (eng_busy) begin
         ecnt_in = ecnt_ff - 6'd1;
         if (ediv_ff) begin
            dr_in = ge ? rdiff[15:0] : rsh[15:0];
            dq_in = {dq_ff[46:0], ge};
         end else begin
            mh_in = {msum[35], msum[35:1]};
            ml_in = {msum[0], ml_ff[33:1]};
         end
      end else if (mul_go) begin
         // Multiply by the magnitude of b and fold its sign into a.
         mm_in   = mul_b[33] ? -{mul_a[33], mul_a} : {mul_a[33], mul_a};
         ml_in   = mul_b[33] ? 34'(-mul_b) : 34'(mul_b);
         mh_in   = 36'sd0;
         ediv_in = 1'b0;
         ecnt_in = MUL_STEPS;
      end else if (div_go) begin
         dq_in   = div_n;
         dr_in   = 16'd0;
         dd_in   = div_d;
         ediv_in = 1'b1;
         ecnt_in = DIV_STEPS;
      end
   end

   always_comb begin
      logic signed [17:0]     dtmp, dhv, dabs;
      logic [1:0]             cnt_ax, n_eff;
      logic [COUNT_WIDTH-1:0] cur_a, cur_b, dif_a, dif_b;
      logic [23:0]            scale_ax;
      logic signed [57:0]     tot, rnd16;
      logic signed [67:0]     v68, mag;
      logic signed [24:0]     offs_ax;
      logic [19:0]            rot_base;
      logic [17:0]            m18, mbase;
      logic [1:0]             quad;
      logic [15:0]            r16, rr16;
      logic [31:0]            kv, pn, pv;
      logic [16:0]            rd_mod, mr_mod;
      logic signed [31:0]     trav;

      rd_mod   = (req_data.heading_reading >= FULL_TURN) ?
                 req_data.heading_reading - FULL_TURN : req_data.heading_reading;
      mr_mod   = (mrot_ff >= FULL_TURN) ? mrot_ff - FULL_TURN : mrot_ff;
      rot_base = 20'({last_head_ff, 1'b0}) + 20'({mr_mod, 1'b0});
      cnt_ax   = ax_ff ? ycnt_ff : xcnt_ff;
      n_eff    = (cnt_ax > TRACK_MAX) ? TRACK_MAX : cnt_ax;
      cur_a    = ax_ff ? in_ff.y_enc_a[COUNT_WIDTH-1:0] : in_ff.x_enc_a[COUNT_WIDTH-1:0];
      cur_b    = ax_ff ? in_ff.y_enc_b[COUNT_WIDTH-1:0] : in_ff.x_enc_b[COUNT_WIDTH-1:0];
      dif_a    = cur_a - (ax_ff ? last_y_ff[0] : last_x_ff[0]);
      dif_b    = cur_b - (ax_ff ? last_y_ff[1] : last_x_ff[1]);
      scale_ax = ax_ff ? yscale_ff : xscale_ff;
      offs_ax  = ax_ff ? 25'($signed(yoff_ff)) : -25'($signed(xoff_ff));
      dtmp     = $signed({1'b0, rd_ff}) - $signed({1'b0, last_head_ff});
      if (dtmp > 18'sd46080)
         dhv = dtmp - 18'sd92160;
      else if (dtmp <= -18'sd46080)
         dhv = dtmp + 18'sd92160;
      else
         dhv = dtmp;
      dabs     = (dh_ff < 0) ? -dh_ff : dh_ff;
      tot      = sum_ff + ((n_eff >= 2'd2) ? 58'(mprod) : 58'sd0);
      rnd16    = (sum_ff + 58'sd32768) >>> 16;
      trav     = (n_eff == 2'd0) ? 32'sd0 : sat32(68'(rnd16));
      v68      = (mprod + 68'sd536870912) >>> 30;
      kv       = v68[31:0];
      mag      = (mprod < 0) ? -mprod : mprod;
      m18      = sarg_ff[17:0];
      if (m18 >= 18'd138240) begin
         quad = 2'd3; mbase = 18'd138240;
      end else if (m18 >= 18'd92160) begin
         quad = 2'd2; mbase = 18'd92160;
      end else if (m18 >= 18'd46080) begin
         quad = 2'd1; mbase = 18'd46080;
      end else begin
         quad = 2'd0; mbase = 18'd0;
      end
      r16      = 16'(m18 - mbase);
      rr16     = quad[0] ? QUART512 - r16 : r16;
      pn       = sin_coef(pi_ff) - mprod[61:30];
      pv       = mprod[61:30];

      pc_in        = pc_ff;
      ret_in       = ret_ff;
      primed_in    = primed_ff;
      acc_x_in     = acc_x_ff;
      acc_y_in     = acc_y_ff;
      last_head_in = last_head_ff;
      last_x_in[0] = last_x_ff[0];
      last_x_in[1] = last_x_ff[1];
      last_y_in[0] = last_y_ff[0];
      last_y_in[1] = last_y_ff[1];
      hen_in       = hen_ff;
      xscale_in    = xscale_ff;
      yscale_in    = yscale_ff;
      xoff_in      = xoff_ff;
      yoff_in      = yoff_ff;
      xcnt_in      = xcnt_ff;
      ycnt_in      = ycnt_ff;
      mrot_in      = mrot_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_in       = rsp_ff;
      in_in        = in_ff;
      rd_in        = rd_ff;
      dh_in        = dh_ff;
      large_in     = large_ff;
      ax_in        = ax_ff;
      sum_in       = sum_ff;
      lx_in        = lx_ff;
      ly_in        = ly_ff;
      sdh_in       = sdh_ff;
      k_in         = k_ff;
      t_in         = t_ff;
      sarg_in      = sarg_ff;
      sneg_in      = sneg_ff;
      x_in         = x_ff;
      x2_in        = x2_ff;
      pi_in        = pi_ff;
      sn_in        = sn_ff;
      rs_in        = rs_ff;
      rc_in        = rc_ff;
      mul_go       = 1'b0;
      div_go       = 1'b0;
      mul_a        = 34'sd0;
      mul_b        = 34'sd0;
      div_n        = 48'd0;
      div_d        = 16'd0;

      if (csr_valid) begin
         case (csr_index)
            CSR_HEADING_ENABLE:  hen_in    = csr_wdata[0];
            CSR_X_TRAVEL_SCALE:  xscale_in = csr_wdata;
            CSR_Y_TRAVEL_SCALE:  yscale_in = csr_wdata;
            CSR_X_ARC_OFFSET:    xoff_in   = csr_wdata;
            CSR_Y_ARC_OFFSET:    yoff_in   = csr_wdata;
            CSR_X_TRACKER_COUNT: xcnt_in   = csr_wdata[1:0];
            CSR_Y_TRACKER_COUNT: ycnt_in   = csr_wdata[1:0];
            CSR_MOUNT_ROTATION:  mrot_in   = csr_wdata[16:0];
            default: ;
         endcase
      end

      if (go) begin
         case (pc_ff)
            ST_IDLE: begin
               if (accept) begin
                  in_in = req_data;
                  rd_in = rd_mod;
                  pc_in = ST_START;
               end
            end
            ST_START: begin
               if (!primed_ff) begin
                  last_head_in = rd_ff;
                  last_x_in[0] = in_ff.x_enc_a[COUNT_WIDTH-1:0];
                  last_x_in[1] = in_ff.x_enc_b[COUNT_WIDTH-1:0];
                  last_y_in[0] = in_ff.y_enc_a[COUNT_WIDTH-1:0];
                  last_y_in[1] = in_ff.y_enc_b[COUNT_WIDTH-1:0];
                  primed_in    = 1'b1;
                  large_in     = 1'b0;
                  pc_in        = ST_OUT;
               end else begin
                  dh_in        = hen_ff ? dhv : 18'sd0;
                  large_in     = hen_ff && (dhv > 18'sd5120 || dhv < -18'sd5120);
                  // With the heading enabled, the new heading is the reading itself, since the turn is taken from it.
                  last_head_in = hen_ff ? rd_ff : last_head_ff;
                  ax_in        = 1'b0;
                  pc_in        = ST_TRV0;
               end
            end
            ST_TRV0: begin
               mul_go = 1'b1;
               mul_a  = 34'($signed(dif_a));
               mul_b  = 34'(scale_ax);
               pc_in  = ST_TRV1;
            end
            ST_TRV1: begin
               sum_in = (n_eff >= 2'd1) ? 58'(mprod) : 58'sd0;
               mul_go = 1'b1;
               mul_a  = 34'($signed(dif_b));
               mul_b  = 34'(scale_ax);
               pc_in  = ST_TRV2;
            end
            ST_TRV2: begin
               // Halving rounds toward zero, as an integer divide does.
               if (n_eff == 2'd2)
                  sum_in = (tot + ((tot < 0) ? 58'sd1 : 58'sd0)) >>> 1;
               else
                  sum_in = tot;
               pc_in = ST_TRV3;
            end
            ST_TRV3: begin
               if (ax_ff) begin
                  ly_in        = trav;
                  last_y_in[0] = cur_a;
                  last_y_in[1] = cur_b;
                  pc_in        = (dh_ff <= 18'sd12 && dh_ff >= -18'sd12) ? ST_ROT0 : ST_ARC0;
               end else begin
                  lx_in        = trav;
                  last_x_in[0] = cur_a;
                  last_x_in[1] = cur_b;
                  ax_in        = 1'b1;
                  pc_in        = ST_TRV0;
               end
            end
            ST_ARC0: begin
               sarg_in = 20'(dh_ff);
               ret_in  = ST_ARC1;
               pc_in   = ST_SIN0;
            end
            ST_ARC1: begin
               sdh_in = sn_ff;
               mul_go = 1'b1;
               mul_a  = 34'(sn_ff);
               mul_b  = 34'sd92160;
               pc_in  = ST_ARC2;
            end
            ST_ARC2: begin
               // The sine of half the turn has the sign of the turn, so the quotient is positive.
               div_go = 1'b1;
               div_n  = mag[47:0];
               div_d  = dabs[15:0];
               pc_in  = ST_ARC3;
            end
            ST_ARC3: begin
               mul_go = 1'b1;
               mul_a  = $signed(INVPI_Q30);
               mul_b  = $signed(34'(dq_ff[32:0]));
               pc_in  = ST_ARC4;
            end
            ST_ARC4: begin
               k_in   = kv;
               ax_in  = 1'b0;
               mul_go = 1'b1;
               mul_a  = 34'(lx_ff);
               mul_b  = $signed(34'(kv));
               pc_in  = ST_ARC5;
            end
            ST_ARC5: begin
               t_in   = mprod;
               mul_go = 1'b1;
               mul_a  = 34'(offs_ax);
               mul_b  = 34'($signed({sdh_ff, 1'b0}));
               pc_in  = ST_ARC6;
            end
            ST_ARC6: begin
               t_in  = t_ff + mprod;
               pc_in = ST_ARC7;
            end
            ST_ARC7: begin
               if (ax_ff) begin
                  ly_in = sat32((t_ff + 68'sd536870912) >>> 30);
                  pc_in = ST_ROT0;
               end else begin
                  lx_in  = sat32((t_ff + 68'sd536870912) >>> 30);
                  ax_in  = 1'b1;
                  mul_go = 1'b1;
                  mul_a  = 34'(ly_ff);
                  mul_b  = $signed(34'(k_ff));
                  pc_in  = ST_ARC5;
               end
            end
            ST_ROT0: begin
               sarg_in = $signed(rot_base);
               ret_in  = ST_ROT1;
               pc_in   = ST_SIN0;
            end
            ST_ROT1: begin
               rs_in   = sn_ff;
               sarg_in = $signed(rot_base + 20'(QUART512));
               ret_in  = ST_ROT2;
               pc_in   = ST_SIN0;
            end
            ST_ROT2: begin
               rc_in  = sn_ff;
               mul_go = 1'b1;
               mul_a  = 34'(lx_ff);
               mul_b  = 34'(sn_ff);
               pc_in  = ST_ROT3;
            end
            ST_ROT3: begin
               t_in   = mprod;
               mul_go = 1'b1;
               mul_a  = 34'(ly_ff);
               mul_b  = 34'(rs_ff);
               pc_in  = ST_ROT4;
            end
            ST_ROT4: begin
               v68      = (t_ff + mprod + 68'sd536870912) >>> 30;
               acc_x_in = acc_x_ff + v68[31:0];
               mul_go   = 1'b1;
               mul_a    = 34'(ly_ff);
               mul_b    = 34'(rc_ff);
               pc_in    = ST_ROT5;
            end
            ST_ROT5: begin
               t_in   = mprod;
               mul_go = 1'b1;
               mul_a  = 34'(lx_ff);
               mul_b  = 34'(rs_ff);
               pc_in  = ST_ROT6;
            end
            ST_ROT6: begin
               v68      = (t_ff - mprod + 68'sd536870912) >>> 30;
               acc_y_in = acc_y_ff + v68[31:0];
               pc_in    = ST_OUT;
            end
            ST_SIN0: begin
               // Fold the angle into one turn, then into the first quadrant.
               if (sarg_ff < 0)
                  sarg_in = sarg_ff + 20'sd184320;
               else if (sarg_ff >= 20'sd184320)
                  sarg_in = sarg_ff - 20'sd184320;
               else begin
                  sneg_in = quad[1];
                  div_go  = 1'b1;
                  div_n   = 48'(rr16) << 30;
                  div_d   = QUART512;
                  pc_in   = ST_SIN1;
               end
            end
            ST_SIN1: begin
               x_in   = dq_ff[30:0];
               mul_go = 1'b1;
               mul_a  = $signed(34'(dq_ff[30:0]));
               mul_b  = $signed(34'(dq_ff[30:0]));
               pc_in  = ST_SIN2;
            end
            ST_SIN2: begin
               x2_in  = mprod[60:30];
               pi_in  = 2'd0;
               mul_go = 1'b1;
               mul_a  = $signed(34'(SIN_C9));
               mul_b  = $signed(34'(mprod[60:30]));
               pc_in  = ST_SIN3;
            end
            ST_SIN3: begin
               mul_go = 1'b1;
               mul_a  = $signed(34'(pn));
               if (pi_ff != 2'd3) begin
                  pi_in = pi_ff + 2'd1;
                  mul_b = $signed(34'(x2_ff));
               end else begin
                  mul_b = $signed(34'(x_ff));
                  pc_in = ST_SIN4;
               end
            end
            ST_SIN4: begin
               if (pv > 32'd1073741824)
                  pv = 32'd1073741824;
               sn_in = sneg_ff ? -$signed(pv) : $signed(pv);
               pc_in = ret_ff;
            end
            ST_OUT: begin
               if (!(rsp_valid_ff && rsp_stall)) begin
                  rsp_in.pos_x       = acc_x_ff;
                  rsp_in.pos_y       = acc_y_ff;
                  rsp_in.heading_out = last_head_ff;
                  rsp_in.large_turn  = large_ff;
                  rsp_valid_in       = 1'b1;
                  pc_in              = ST_IDLE;
               end
            end
            default: pc_in = ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= ST_IDLE;
         primed_ff    <= 1'b0;
         acc_x_ff     <= 32'd0;
         acc_y_ff     <= 32'd0;
         last_head_ff <= 17'd0;
         last_x_ff[0] <= '0;
         last_x_ff[1] <= '0;
         last_y_ff[0] <= '0;
         last_y_ff[1] <= '0;
         hen_ff       <= 1'b1;
         xscale_ff    <= 24'd65536;
         yscale_ff    <= 24'd65536;
         xoff_ff      <= 24'd0;
         yoff_ff      <= 24'd0;
         xcnt_ff      <= 2'd1;
         ycnt_ff      <= 2'd1;
         mrot_ff      <= 17'd0;
         rsp_valid_ff <= 1'b0;
         ecnt_ff      <= 6'd0;
      end else begin
         pc_ff        <= pc_in;
         primed_ff    <= primed_in;
         acc_x_ff     <= acc_x_in;
         acc_y_ff     <= acc_y_in;
         last_head_ff <= last_head_in;
         last_x_ff[0] <= last_x_in[0];
         last_x_ff[1] <= last_x_in[1];
         last_y_ff[0] <= last_y_in[0];
         last_y_ff[1] <= last_y_in[1];
         hen_ff       <= hen_in;
         xscale_ff    <= xscale_in;
         yscale_ff    <= yscale_in;
         xoff_ff      <= xoff_in;
         yoff_ff      <= yoff_in;
         xcnt_ff      <= xcnt_in;
         ycnt_ff      <= ycnt_in;
         mrot_ff      <= mrot_in;
         rsp_valid_ff <= rsp_valid_in;
         ecnt_ff      <= ecnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff   <= ret_in;
      rsp_ff   <= rsp_in;
      in_ff    <= in_in;
      rd_ff    <= rd_in;
      dh_ff    <= dh_in;
      large_ff <= large_in;
      ax_ff    <= ax_in;
      sum_ff   <= sum_in;
      lx_ff    <= lx_in;
      ly_ff    <= ly_in;
      sdh_ff   <= sdh_in;
      k_ff     <= k_in;
      t_ff     <= t_in;
      sarg_ff  <= sarg_in;
      sneg_ff  <= sneg_in;
      x_ff     <= x_in;
      x2_ff    <= x2_in;
      pi_ff    <= pi_in;
      sn_ff    <= sn_in;
      rs_ff    <= rs_in;
      rc_ff    <= rc_in;
      mh_ff    <= mh_in;
      ml_ff    <= ml_in;
      mm_ff    <= mm_in;
      dq_ff    <= dq_in;
      dr_ff    <= dr_in;
      dd_ff    <= dd_in;
      ediv_ff  <= ediv_in;
   end

endmodule

FILE: src/tow_checker.sv
// Port-level checker for the odometry block and the bind that attaches it.
module tow_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input tow_pkg::req_type               req_data,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input tow_pkg::rsp_type               rsp_data,
   input logic                           csr_valid,
   input logic                           csr_ready,
   input logic [tow_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [tow_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tow_pkg::*;

   // A held result word keeps its value until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // A result word only goes away once it has been taken.
   a_rsp_drop: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(rsp_valid) |-> $past(!rsp_stall))
      else $error("result word dropped without being taken");

   // Once a word is accepted the block is busy with it.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word accepted while the first is at work");

   // The reported heading always lies within one turn.
   a_heading: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.heading_out < FULL_TURN)
      else $error("heading out of range");

endmodule

bind tracking_wheel_odometry tow_checker u_tow_checker (.*);

FILE: sim/tracking_wheel_odometry_test.sv
// Self-checking testbench for the tracking wheel odometry block with its own pose predictor.
module tracking_wheel_odometry_test;
   import tow_pkg::*;

   localparam int FULL = 92160;
   localparam int Q512 = 46080;
   localparam longint unsigned K1 = 1686629713, K3 = 693598668, K5 = 85569306;
   localparam longint unsigned K7 = 5026995, K9 = 172272;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall, csr_valid, csr_ready;
   req_type req_data;
   rsp_type rsp_data;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tracking_wheel_odometry i_dut (.*);

   req_type pending_words[$];
   rsp_type pose_expected[$];
   int failures = 0;
   bit steady = 0;

   // Predictor registers and state.
   logic        m_hdg_en;
   logic [23:0] m_x_scale, m_y_scale, m_x_offs, m_y_offs;
   logic [1:0]  m_x_cnt, m_y_cnt;
   logic [16:0] m_mount;
   logic [16:0] m_heading;
   logic [31:0] m_last_x [2], m_last_y [2];
   logic [31:0] m_pos_x, m_pos_y;
   bit          m_primed;

   // Generator state for well-formed motion.
   int gen_h = 0;
   logic [31:0] gen_c [4];

   function automatic longint round_shift(longint v, int sh);
      return (v + (longint'(1) << (sh - 1))) >>> sh;
   endfunction

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint quarter_wave(longint r);
      longint unsigned x, x2, p;
      x = (unsigned'(r) << 30) / Q512;
      x2 = (x * x) >> 30;
      p = K9;
      p = K7 - ((p * x2) >> 30);
      p = K5 - ((p * x2) >> 30);
      p = K3 - ((p * x2) >> 30);
      p = K1 - ((p * x2) >> 30);
      p = (p * x) >> 30;
      if (p > 64'd1073741824) p = 64'd1073741824;
      return longint'(p);
   endfunction

   // Sine of an angle in 1/512 degree, Q30.
   function automatic longint sine_512(longint a);
      longint m, q, r;
      m = a % (2 * FULL);
      if (m < 0) m += 2 * FULL;
      q = m / Q512;
      r = m % Q512;
      case (q)
         0: return quarter_wave(r);
         1: return quarter_wave(Q512 - r);
         2: return -quarter_wave(r);
         default: return -quarter_wave(Q512 - r);
      endcase
   endfunction

   function automatic longint mean_travel(logic [31:0] e0, e1, l0, l1, logic [1:0] cnt,
                                          logic [23:0] scale);
      longint sum, n;
      n = longint'((cnt > TRACK_MAX) ? TRACK_MAX : cnt);
      sum = 0;
      if (n > 0) sum += longint'(int'(e0 - l0)) * longint'(scale);
      if (n > 1) sum += longint'(int'(e1 - l1)) * longint'(scale);
      if (n == 0) return 0;
      return clip32(round_shift(sum / n, 16));
   endfunction

   function automatic longint chord_step(longint d, longint offs, longint dh);
      longint s, q, k;
      if (dh <= 12 && dh >= -12) return d;
      s = sine_512(dh);
      q = (2 * s * Q512) / dh;
      k = round_shift(q * 64'sd341782638, 30);
      return clip32(round_shift(d * k + offs * 2 * s, 30));
   endfunction

   function automatic rsp_type predict_pose(req_type w);
      rsp_type r;
      longint rd, dh, lx, ly, ang, mr, c, s;
      rd = w.heading_reading;
      if (rd >= FULL) rd -= FULL;
      dh = 0;
      r.large_turn = 1'b0;
      if (!m_primed) begin
         m_heading = 17'(rd);
         m_primed = 1;
      end else begin
         if (m_hdg_en) begin
            dh = rd - longint'(m_heading);
            if (dh > FULL / 2) dh -= FULL;
            if (dh <= -(FULL / 2)) dh += FULL;
         end
         lx = mean_travel(w.x_enc_a, w.x_enc_b, m_last_x[0], m_last_x[1], m_x_cnt, m_x_scale);
         ly = mean_travel(w.y_enc_a, w.y_enc_b, m_last_y[0], m_last_y[1], m_y_cnt, m_y_scale);
         lx = chord_step(lx, -longint'(signed'(m_x_offs)), dh);
         ly = chord_step(ly, longint'(signed'(m_y_offs)), dh);
         ang = longint'(m_heading) + dh;
         if (ang >= FULL) ang -= FULL;
         if (ang < 0) ang += FULL;
         m_heading = 17'(ang);
         r.large_turn = (dh > 5120 || dh < -5120);
         mr = m_mount;
         if (mr >= FULL) mr -= FULL;
         ang = 2 * (ang + mr);
         s = sine_512(ang);
         c = sine_512(ang + Q512);
         m_pos_x += 32'(round_shift(lx * c + ly * s, 30));
         m_pos_y += 32'(round_shift(ly * c - lx * s, 30));
      end
      // Both stored counts follow every word, whatever the tracker count.
      m_last_x[0] = w.x_enc_a;
      m_last_x[1] = w.x_enc_b;
      m_last_y[0] = w.y_enc_a;
      m_last_y[1] = w.y_enc_b;
      r.pos_x = m_pos_x;
      r.pos_y = m_pos_y;
      r.heading_out = m_heading;
      return r;
   endfunction

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("simulation failed");
      $finish;
   end

   // Sender.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
         req_data <= '0;
      end else begin
         if (req_valid && !req_stall) pose_expected = {pose_expected, predict_pose(req_data)};
         if (!req_valid || !req_stall) begin
            if (pending_words.size() > 0 && (steady || $urandom_range(0, 99) >= 36)) begin
               req_valid <= 1;
               req_data <= pending_words.pop_front();
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // Receiver and checker.
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pose_expected.size() == 0) begin
               $display("%0t: unexpected word %h", $time, rsp_data);
               failures++;
            end else begin
               e = pose_expected.pop_front();
               if (rsp_data.pos_x !== e.pos_x) begin
                  $display("%0t: pos_x expected %0d actual %0d", $time, e.pos_x, rsp_data.pos_x);
                  failures++;
               end
               if (rsp_data.pos_y !== e.pos_y) begin
                  $display("%0t: pos_y expected %0d actual %0d", $time, e.pos_y, rsp_data.pos_y);
                  failures++;
               end
               if (rsp_data.heading_out !== e.heading_out) begin
                  $display("%0t: heading_out expected %0d actual %0d", $time, e.heading_out,
                           rsp_data.heading_out);
                  failures++;
               end
               if (rsp_data.large_turn !== e.large_turn) begin
                  $display("%0t: large_turn expected %0d actual %0d", $time, e.large_turn,
                           rsp_data.large_turn);
                  failures++;
               end
            end
         end
         rsp_stall <= !steady && ($urandom_range(0, 99) < 36);
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [23:0] val);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      case (idx)
         CSR_HEADING_ENABLE:  m_hdg_en = val[0];
         CSR_X_TRAVEL_SCALE:  m_x_scale = val;
         CSR_Y_TRAVEL_SCALE:  m_y_scale = val;
         CSR_X_ARC_OFFSET:    m_x_offs = val;
         CSR_Y_ARC_OFFSET:    m_y_offs = val;
         CSR_X_TRACKER_COUNT: m_x_cnt = val[1:0];
         CSR_Y_TRACKER_COUNT: m_y_cnt = val[1:0];
         default:             m_mount = val[16:0];
      endcase
   endtask

   task automatic write_all(logic en, logic [23:0] xs, ys, xo, yo, logic [1:0] xc, yc,
                            logic [16:0] mr);
      write_reg(CSR_HEADING_ENABLE, 24'(en));
      write_reg(CSR_X_TRAVEL_SCALE, xs);
      write_reg(CSR_Y_TRAVEL_SCALE, ys);
      write_reg(CSR_X_ARC_OFFSET, xo);
      write_reg(CSR_Y_ARC_OFFSET, yo);
      write_reg(CSR_X_TRACKER_COUNT, 24'(xc));
      write_reg(CSR_Y_TRACKER_COUNT, 24'(yc));
      write_reg(CSR_MOUNT_ROTATION, 24'(mr));
   endtask

   task automatic push_word(int h, logic [31:0] xa, xb, ya, yb);
      req_type w;
      w.heading_reading = 17'(h);
      w.x_enc_a = xa;
      w.x_enc_b = xb;
      w.y_enc_a = ya;
      w.y_enc_b = yb;
      pending_words = {pending_words, w};
      gen_h = (h >= FULL) ? h - FULL : h;
      gen_c = '{xa, xb, ya, yb};
   endtask

   // Mostly plausible motion with random content; some words are pure noise.
   task automatic push_random_words(int n);
      int dh, pick, h;
      logic [31:0] c [4];
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            push_word($urandom_range(0, 131071), $urandom, $urandom, $urandom, $urandom);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 50) dh = int'($urandom_range(0, 24)) - 12;
            else if (pick < 80) dh = int'($urandom_range(0, 1200)) - 600;
            else dh = int'($urandom_range(0, 18000)) - 9000;
            h = (gen_h + dh + FULL) % FULL;
            if (h < 131072 - FULL && $urandom_range(0, 19) == 0) h += FULL;
            foreach (c[i]) begin
               if ($urandom_range(0, 19) == 0)
                  c[i] = gen_c[i] + 32'(int'($urandom_range(0, 2097152)) - 1048576);
               else
                  c[i] = gen_c[i] + 32'(int'($urandom_range(0, 8192)) - 4096);
            end
            push_word(h, c[0], c[1], c[2], c[3]);
         end
      end
   endtask

   task automatic drain;
      do @(posedge clock); while (pending_words.size() > 0 || req_valid ||
                                  pose_expected.size() > 0);
   endtask

   initial begin
      reset = 1;
      csr_valid = 0;
      csr_index = '0;
      csr_wdata = '0;
      m_hdg_en = 1'b1;
      m_x_scale = 24'd65536;
      m_y_scale = 24'd65536;
      m_x_offs = 24'd0;
      m_y_offs = 24'd0;
      m_x_cnt = 2'd1;
      m_y_cnt = 2'd1;
      m_mount = 17'd0;
      m_heading = 17'd0;
      m_last_x = '{0, 0};
      m_last_y = '{0, 0};
      m_pos_x = 0;
      m_pos_y = 0;
      m_primed = 0;
      repeat (5) @(posedge clock);
      reset <= 0;

      write_all(1'b1, 24'd65536, 24'd65536, 24'd0, 24'd0, 2'd1, 2'd1, 17'd0);
      // Priming word with an out-of-range heading, then turns around the thresholds,
      // half turns both ways, heading wrap and encoder wrap.
      push_word(131071, 32'h7fffffff, 32'h80000000, 0, 32'hffffffff);
      push_word(38911 + 5, 32'h80000005, 32'h7ffffff0, 32'h7fffffff, 32'h00000010);
      push_word(38916 + 13, 32'h80000105, 32'h7fffff00, 32'h80000000, 32'h00000020);
      push_word(38929 + 46080, 32'h80001105, 32'h7ffff000, 32'h80001000, 32'hfffff000);
      push_word(38929, 32'h80002105, 32'h7fffe000, 32'h80002000, 32'hffffe000);
      push_word(0, 32'h80003105, 32'h7fffd000, 32'h80003000, 32'hffffd000);
      push_word(92159, 32'h80004105, 32'h7fffc000, 32'h80004000, 32'hffffc000);
      push_word(5120 - 1, 32'h80005105, 32'h7fffb000, 32'h80005000, 32'hffffb000);
      push_word(5120 + 5119 + 1, 32'h80005105, 32'h7fffb000, 32'h80005000, 32'hffffb000);
      push_word(92160, 32'h00000000, 32'h00000000, 32'h7fffffff, 32'h80000000);
      push_word(12, 32'h7fffffff, 32'h80000000, 32'h00000000, 32'h00000000);
      push_word(0, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      push_random_words(160);
      drain();

      write_all(1'b0, 24'hffffff, 24'hffffff, 24'h800000, 24'h7fffff, 2'd2, 2'd3, 17'd92159);
      push_word(gen_h, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
      push_word(gen_h + 30000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
      push_random_words(170);
      drain();

      write_all(1'b1, 24'd0, 24'h7fffff, 24'h7fffff, 24'h800000, 2'd0, 2'd2, 17'd131071);
      push_random_words(170);
      drain();

      // A stretch with neither side idling.
      steady = 1;
      write_all(1'($urandom_range(0, 1)), 24'($urandom), 24'($urandom), 24'($urandom),
                24'($urandom), 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                17'($urandom_range(0, 131071)));
      push_random_words(170);
      drain();
      steady = 0;

      repeat (2) begin
         write_all(1'b1, 24'($urandom_range(0, 262143)), 24'($urandom_range(0, 262143)),
                   24'($urandom), 24'($urandom), 2'($urandom_range(0, 3)),
                   2'($urandom_range(0, 3)), 17'($urandom_range(0, 131071)));
         push_random_words(180);
         drain();
      end

      repeat (2000) @(posedge clock);
      if (failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

FILE: files.f
src/tow_pkg.sv
src/tracking_wheel_odometry.sv
src/tow_checker.sv
sim/tracking_wheel_odometry_test.sv
